@@ design/spq_pkg.sv @@
package spq_pkg;

  // queue geometry
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int OUT_CNT_W = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [VAL_W-1:0] word_t;

  // memory access issued by the sequencer
  typedef struct packed {
    logic  we;
    idx_t  waddr;
    word_t wdata;
    idx_t  raddr;
  } ram_req_t;

  // one finished result word
  typedef struct packed {
    logic                 accepted;
    word_t                head_value;
    logic [OUT_CNT_W-1:0] entry_count;
    logic                 is_empty;
    logic                 is_full;
  } result_t;

  function automatic idx_t next_slot(input idx_t i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
  endfunction

  function automatic idx_t prev_slot(input idx_t i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : idx_t'(i - 1'b1);
  endfunction

endpackage

@@ design/spq_ram.sv @@
module spq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/spq_ctrl.sv @@
module spq_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_command,
  input  logic [31:0]            in_new_value,
  output spq_pkg::ram_req_t      ram_req,
  input  spq_pkg::word_t         ram_rdata,
  output logic                   res_valid,
  input  logic                   res_ready,
  output spq_pkg::result_t       res
);
  import spq_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CMP  = 3'd1;
  localparam logic [2:0] ST_PUT  = 3'd2;
  localparam logic [2:0] ST_RLD  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;
  idx_t       pos_r, pos_nxt;
  idx_t       head_idx_r, head_idx_nxt;
  idx_t       tail_idx_r, tail_idx_nxt;
  cnt_t       cnt_r, cnt_nxt;
  word_t      head_val_r, head_val_nxt;
  word_t      val_r, val_nxt;
  logic       ok_r, ok_nxt;
  logic       in_fire;
  logic       is_full, is_empty;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign is_full  = (cnt_r == CNT_W'(DEPTH));
  assign is_empty = (cnt_r == '0);

  // sequencer: an insert shifts one entry per cycle from the tail toward the head; a remove advances the head
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    head_idx_nxt  = head_idx_r;
    tail_idx_nxt  = tail_idx_r;
    cnt_nxt       = cnt_r;
    head_val_nxt  = head_val_r;
    val_nxt       = val_r;
    ok_nxt        = ok_r;
    ram_req.we    = 1'b0;
    ram_req.waddr = pos_r;
    ram_req.wdata = val_r;
    ram_req.raddr = pos_r;
    case (state_r)
      ST_IDLE: begin
        if (in_command == CMD_REMOVE) begin
          ram_req.raddr = next_slot(head_idx_r);
        end else begin
          ram_req.raddr = prev_slot(tail_idx_r);
        end
        if (in_fire) begin
          val_nxt = in_new_value;
          if (in_command == CMD_REMOVE) begin
            if (is_empty) begin
              ok_nxt    = 1'b0;
              state_nxt = ST_FIN;
            end else begin
              ok_nxt       = 1'b1;
              head_idx_nxt = next_slot(head_idx_r);
              cnt_nxt      = cnt_t'(cnt_r - 1'b1);
              state_nxt    = (cnt_r > CNT_W'(1)) ? ST_RLD : ST_FIN;
            end
          end else begin
            pos_nxt = tail_idx_r;
            if (is_full) begin
              ok_nxt    = 1'b0;
              state_nxt = ST_FIN;
            end else if (is_empty) begin
              state_nxt = ST_PUT;
            end else begin
              state_nxt = ST_CMP;
            end
          end
        end
      end
      ST_CMP: begin
        ram_req.raddr = prev_slot(prev_slot(pos_r));
        if ($signed(val_r) < $signed(ram_rdata)) begin
          // larger entry moves one slot toward the tail
          ram_req.we    = 1'b1;
          ram_req.wdata = ram_rdata;
          pos_nxt       = prev_slot(pos_r);
          if (prev_slot(pos_r) == head_idx_r) begin
            state_nxt = ST_PUT;
          end
        end else begin
          state_nxt = ST_PUT;
        end
      end
      ST_PUT: begin
        ram_req.we   = 1'b1;
        ok_nxt       = 1'b1;
        tail_idx_nxt = next_slot(tail_idx_r);
        cnt_nxt      = cnt_t'(cnt_r + 1'b1);
        if (pos_r == head_idx_r) begin
          head_val_nxt = val_r;
        end
        state_nxt = ST_FIN;
      end
      ST_RLD: begin
        // new head word arrives from memory
        head_val_nxt = ram_rdata;
        state_nxt    = ST_FIN;
      end
      ST_FIN: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result word built from the settled state
  assign res_valid       = (state_r == ST_FIN);
  assign res.accepted    = ok_r;
  assign res.head_value  = is_empty ? '0 : head_val_r;
  assign res.entry_count = OUT_CNT_W'(cnt_r);
  assign res.is_empty    = is_empty;
  assign res.is_full     = is_full;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      head_idx_r <= '0;
      tail_idx_r <= '0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      head_idx_r <= head_idx_nxt;
      tail_idx_r <= tail_idx_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    head_val_r <= head_val_nxt;
    val_r      <= val_nxt;
    ok_r       <= ok_nxt;
  end

endmodule

@@ design/sorted_insert_priority_queue.sv @@
// Sorted priority queue of up to 16 signed 32-bit words, held ascending in a
// circular buffer in one memory (one write port, one registered read port).
// An insert walks from the tail toward the head, moving one larger entry per
// cycle in the compare state (skipped when the queue is empty), then writes
// the new word in the put state before its result is offered. A remove goes
// through the head reload state unless it empties the queue, and a refused
// insert or remove goes straight to the result. The smallest word is kept
// in a register, so every result reports it without a memory read. One item is
// in work at a time; a finished result waits in the output register while the
// next word is taken in.
module sorted_insert_priority_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic signed [31:0] in_new_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_accepted,
  output logic signed [31:0] out_head_value,
  output logic [4:0]         out_entry_count,
  output logic               out_is_empty,
  output logic               out_is_full
);
  import spq_pkg::*;

  ram_req_t ram_req;
  word_t    ram_rdata;
  logic     res_valid;
  logic     res_ready;
  result_t  res;
  logic     out_valid_r;
  result_t  out_r;

  spq_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_req.we),
    .waddr(ram_req.waddr),
    .wdata(ram_req.wdata),
    .raddr(ram_req.raddr),
    .rdata(ram_rdata)
  );

  spq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_command  (in_command),
    .in_new_value(in_new_value),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // output register
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = out_r.accepted;
  assign out_head_value  = $signed(out_r.head_value);
  assign out_entry_count = out_r.entry_count;
  assign out_is_empty    = out_r.is_empty;
  assign out_is_full     = out_r.is_full;

`ifndef NO_ASSERTIONS
  // an accepted word keeps the sequencer busy in the cycle after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after acceptance");

  // the sequencer never offers a result while it is idle
  a_no_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !res_valid)
    else $error("result offered while idle");

  // the empty flag agrees with the reported count, and empty and full are never both set
  a_flags_match_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_is_empty == (out_entry_count == 5'd0)) &&
                   !(out_is_empty && out_is_full)))
    else $error("empty/full flags disagree with count");
`endif

endmodule

@@ test/sorted_insert_priority_queue_tb.sv @@
`timescale 1ns / 100ps

module sorted_insert_priority_queue_tb;
  import spq_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = DEPTH + 8;
  localparam int DIR_ROWS = 25;

  typedef struct packed {
    logic    cmd;
    word_t   val;
    logic    typed;
    result_t res;
  } stim_row_t;

  typedef enum logic [1:0] {TREND_FILL, TREND_DRAIN, TREND_MIX} trend_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_command;
  logic signed [31:0] in_new_value;
  logic               out_valid;
  logic               out_ready;
  logic               out_accepted;
  logic signed [31:0] out_head_value;
  logic [4:0]         out_entry_count;
  logic               out_is_empty;
  logic               out_is_full;

  // copy of the sorted circular buffer
  word_t sorted_copy [DEPTH];
  int    copy_head;
  int    copy_tail;
  int    copy_count;

  result_t expected_results [$];
  int      error_count;
  int      result_index;
  int      stall_cycles;
  int      send_idle_pct;
  int      recv_idle_pct;
  trend_t  trend;

  // directed words: reset, extremes, duplicates, full and empty refusals, head wrap
  stim_row_t directed_rows [DIR_ROWS] = '{
    '{CMD_REMOVE, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 5'd0, 1'b1, 1'b0}},
    '{CMD_INSERT, 32'h7fff_ffff, 1'b1, '{1'b1, 32'h7fff_ffff, 5'd1, 1'b0, 1'b0}},
    '{CMD_INSERT, 32'h8000_0000, 1'b1, '{1'b1, 32'h8000_0000, 5'd2, 1'b0, 1'b0}},
    '{CMD_INSERT, 32'h0000_0000, 1'b0, '0},
    '{CMD_INSERT, 32'hffff_ffff, 1'b0, '0},
    '{CMD_INSERT, 32'h0000_0001, 1'b0, '0},
    '{CMD_INSERT, 32'h0000_0005, 1'b0, '0},
    '{CMD_INSERT, 32'h0000_0005, 1'b0, '0},
    '{CMD_INSERT, 32'h0000_0003, 1'b0, '0},
    '{CMD_INSERT, 32'h7fff_ffff, 1'b0, '0},
    '{CMD_INSERT, 32'h8000_0001, 1'b0, '0},
    '{CMD_INSERT, 32'h0000_0064, 1'b0, '0},
    '{CMD_INSERT, 32'hffff_ff9c, 1'b0, '0},
    '{CMD_INSERT, 32'h0000_002a, 1'b0, '0},
    '{CMD_INSERT, 32'h0000_0007, 1'b0, '0},
    '{CMD_INSERT, 32'hffff_fff9, 1'b0, '0},
    '{CMD_INSERT, 32'h0000_0002, 1'b0, '0},
    '{CMD_INSERT, 32'h0000_007b, 1'b1, '{1'b0, 32'h8000_0000, 5'd16, 1'b0, 1'b1}},
    '{CMD_REMOVE, 32'hdead_beef, 1'b1, '{1'b1, 32'h8000_0001, 5'd15, 1'b0, 1'b0}},
    '{CMD_INSERT, 32'h8000_0000, 1'b0, '0},
    '{CMD_INSERT, 32'h0000_0000, 1'b1, '{1'b0, 32'h8000_0000, 5'd16, 1'b0, 1'b1}},
    '{CMD_REMOVE, 32'hffff_ffff, 1'b0, '0},
    '{CMD_REMOVE, 32'h0000_0000, 1'b0, '0},
    '{CMD_INSERT, 32'h5555_5555, 1'b0, '0},
    '{CMD_INSERT, 32'haaaa_aaaa, 1'b0, '0}
  };

  sorted_insert_priority_queue DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_new_value    (in_new_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_accepted    (out_accepted),
    .out_head_value  (out_head_value),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int slot_after(input int i);
    return (i + 1) % DEPTH;
  endfunction

  function automatic int slot_before(input int i);
    return (i + DEPTH - 1) % DEPTH;
  endfunction

  // apply one word to the sorted copy and return the queue state it leaves
  function automatic result_t apply_to_sorted_copy(input logic cmd, input word_t val);
    result_t r;
    int      pos;
    logic    done;
    done = 1'b0;
    if (cmd == CMD_INSERT) begin
      if (copy_count < DEPTH) begin
        pos = copy_tail;
        // move larger entries one slot toward the tail, stop at the head slot
        while (pos != copy_head &&
               $signed(val) < $signed(sorted_copy[slot_before(pos)])) begin
          sorted_copy[pos] = sorted_copy[slot_before(pos)];
          pos = slot_before(pos);
        end
        sorted_copy[pos] = val;
        copy_tail = slot_after(copy_tail);
        copy_count++;
        done = 1'b1;
      end
    end else if (copy_count > 0) begin
      copy_head = slot_after(copy_head);
      copy_count--;
      done = 1'b1;
    end
    r.accepted    = done;
    r.head_value  = (copy_count != 0) ? sorted_copy[copy_head] : '0;
    r.entry_count = 5'(copy_count);
    r.is_empty    = (copy_count == 0);
    r.is_full     = (copy_count >= DEPTH);
    return r;
  endfunction

  // mix of extremes, a narrow band for duplicates, and full-range values
  function automatic word_t random_word();
    word_t w;
    case ($urandom_range(4))
      0: begin
        case ($urandom_range(5))
          0: w = 32'h8000_0000;
          1: w = 32'h7fff_ffff;
          2: w = 32'h0000_0000;
          3: w = 32'hffff_ffff;
          4: w = 32'h8000_0001;
          default: w = 32'h7fff_fffe;
        endcase
      end
      1: w = word_t'($urandom_range(16)) - 32'd8;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  task automatic compare_field(input string field, input logic [31:0] seen,
                               input logic [31:0] want);
    if (seen !== want)
      report_mismatch($sformatf("result %0d %s got %h expected %h",
                                result_index, field, seen, want));
  endtask

  // offer one word, hold it until taken, then queue its expected result
  task automatic send_word(input logic cmd, input word_t val, input logic typed,
                           input result_t typed_res);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_command   = cmd;
    in_new_value = val;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    predicted = apply_to_sorted_copy(cmd, val);
    expected_results.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  // random words, mostly long fill and drain runs so the queue swings full to empty
  task automatic run_random(input int n_items);
    int   insert_pct;
    logic cmd;
    for (int i = 0; i < n_items; i++) begin
      if (copy_count == DEPTH && $urandom_range(9) < 6)
        trend = TREND_DRAIN;
      else if (copy_count == 0 && $urandom_range(9) < 6)
        trend = TREND_FILL;
      else if ($urandom_range(99) == 0)
        trend = TREND_MIX;
      case (trend)
        TREND_FILL:  insert_pct = 85;
        TREND_DRAIN: insert_pct = 15;
        default:     insert_pct = 50;
      endcase
      cmd = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
      send_word(cmd, random_word(), 1'b0, '0);
    end
  endtask

  // receiver backpressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none expected", result_index));
      end else begin
        compare_field("accepted", 32'(out_accepted), 32'(expected_results[0].accepted));
        compare_field("head_value", out_head_value, expected_results[0].head_value);
        compare_field("entry_count", 32'(out_entry_count),
                      32'(expected_results[0].entry_count));
        compare_field("is_empty", 32'(out_is_empty), 32'(expected_results[0].is_empty));
        compare_field("is_full", 32'(out_is_full), 32'(expected_results[0].is_full));
        void'(expected_results.pop_front());
      end
      result_index++;
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_valid === 1'b1 && in_ready === 1'b1) ||
          (out_valid === 1'b1 && out_ready === 1'b1))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    in_valid      = 1'b0;
    in_command    = CMD_INSERT;
    in_new_value  = '0;
    out_ready     = 1'b0;
    rst_n         = 1'b0;
    copy_head     = 0;
    copy_tail     = 0;
    copy_count    = 0;
    error_count   = 0;
    result_index  = 0;
    stall_cycles  = 0;
    trend         = TREND_FILL;
    send_idle_pct = 19;
    recv_idle_pct = 68;
    for (int i = 0; i < DEPTH; i++) sorted_copy[i] = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      send_word(directed_rows[i].cmd, directed_rows[i].val, directed_rows[i].typed,
                directed_rows[i].res);

    run_random(420);
    send_idle_pct = 68;
    recv_idle_pct = 19;
    run_random(420);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(410);
    in_valid = 1'b0;

    // drain, then give stray results time to show up
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
design/spq_pkg.sv
design/spq_ram.sv
design/spq_ctrl.sv
design/sorted_insert_priority_queue.sv
test/sorted_insert_priority_queue_tb.sv
